### sv/urb_pkg.sv
// shared constants and types for the uart receive and transmit ring buffers
`default_nettype none

package urb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_OW    = RX_AW + 1;
  localparam int TX_OW    = TX_AW + 1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    FUNC_LINE_RX  = 2'd0,
    FUNC_TX_READY = 2'd1,
    FUNC_HOST_PUT = 2'd2,
    FUNC_HOST_GET = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic       line_tx_valid;
    logic [7:0] line_tx_byte;
    logic       host_byte_valid;
    logic [7:0] host_byte;
    logic       accepted;
    logic       tx_irq_enable;
  } rsp_t;

endpackage

`default_nettype wire

### sv/uart_rx_tx_ring_buffers.sv
// top level: event sequencer, queue pointers and the two byte stores
//
// usage
//   one command channel: an event (func, data) is taken at a rising edge
//   where start_i is high and busy_o is low. events are line byte received,
//   transmitter ready, host put and host get.
//   one result channel: done_o is high for exactly one cycle with rsp_o;
//   the result is taken at the edge that ends that cycle. the receiver
//   cannot stall, so no result is ever held back.
// results
//   a result appears in the cycle after the event is taken, save for a
//   newline put, which queues cr and lf through the single write port of
//   the transmit store and so passes through ST_NL first; no new event is
//   taken until the result is done. reads of a store go through its synchronous read port.
// reset
//   rst_ni clears all read and write pointers and the transmit interrupt
//   enable; store contents stay undefined until written, which the
//   occupancy rules never let a read observe.
// queues run as ring buffers with an index and a wrap phase bit per pointer,
// so any depth works, not only powers of two
`default_nettype none

module uart_rx_tx_ring_buffers (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire urb_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output urb_pkg::rsp_t      rsp_o
);

  import urb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NL,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  // pointers: slot index plus wrap phase
  logic [RX_AW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic             rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [TX_AW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic             tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic             tx_en_q, tx_en_d;

  // registered result flags; bytes come from the store read ports
  rsp_t rsp_q, rsp_d;

  // store ports
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       tx_wdata;
  logic [7:0]       rx_rdata, tx_rdata;

  logic [RX_OW-1:0] rx_occ;
  logic [TX_OW-1:0] tx_occ;
  logic             rx_full, rx_empty, tx_full, tx_empty, tx_room2;
  logic             take;
  logic             is_nl;

  // occupancy from index difference, corrected by depth when phases differ
  always_comb begin
    if (rx_wp_q == rx_rp_q) begin
      rx_occ = {1'b0, rx_wr_q} - {1'b0, rx_rd_q};
    end else begin
      rx_occ = {1'b0, rx_wr_q} + RX_OW'(RX_DEPTH) - {1'b0, rx_rd_q};
    end
    if (tx_wp_q == tx_rp_q) begin
      tx_occ = {1'b0, tx_wr_q} - {1'b0, tx_rd_q};
    end else begin
      tx_occ = {1'b0, tx_wr_q} + TX_OW'(TX_DEPTH) - {1'b0, tx_rd_q};
    end
  end

  assign rx_full  = (rx_occ == RX_OW'(RX_DEPTH));
  assign tx_full  = (tx_occ == TX_OW'(TX_DEPTH));
  assign tx_room2 = (tx_occ <= TX_OW'(TX_DEPTH - 2));
  assign rx_empty = (rx_wr_q == rx_rd_q) && (rx_wp_q == rx_rp_q);
  assign tx_empty = (tx_wr_q == tx_rd_q) && (tx_wp_q == tx_rp_q);

  assign take  = start_i && (state_q == ST_IDLE);
  assign is_nl = (req_i.data == CHAR_LF);

  always_comb begin
    state_d  = state_q;
    rx_wr_d  = rx_wr_q;
    rx_wp_d  = rx_wp_q;
    rx_rd_d  = rx_rd_q;
    rx_rp_d  = rx_rp_q;
    tx_wr_d  = tx_wr_q;
    tx_wp_d  = tx_wp_q;
    tx_rd_d  = tx_rd_q;
    tx_rp_d  = tx_rp_q;
    tx_en_d  = tx_en_q;
    rsp_d    = rsp_q;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    tx_wdata = req_i.data;

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          rsp_d   = '0;
          state_d = ST_RESP;
          case (req_i.func)
            FUNC_LINE_RX: begin
              if (!rx_full) begin
                rx_we          = 1'b1;
                rsp_d.accepted = 1'b1;
                if (rx_wr_q == RX_AW'(RX_DEPTH - 1)) begin
                  rx_wr_d = '0;
                  rx_wp_d = ~rx_wp_q;
                end else begin
                  rx_wr_d = rx_wr_q + RX_AW'(1);
                end
              end
            end
            FUNC_TX_READY: begin
              if (tx_empty) begin
                tx_en_d = 1'b0;
              end else begin
                tx_re               = 1'b1;
                rsp_d.line_tx_valid = 1'b1;
                if (tx_rd_q == TX_AW'(TX_DEPTH - 1)) begin
                  tx_rd_d = '0;
                  tx_rp_d = ~tx_rp_q;
                end else begin
                  tx_rd_d = tx_rd_q + TX_AW'(1);
                end
              end
            end
            FUNC_HOST_PUT: begin
              if (is_nl ? tx_room2 : !tx_full) begin
                tx_we          = 1'b1;
                tx_en_d        = 1'b1;
                rsp_d.accepted = 1'b1;
                // newline: cr now, lf in the following cycle
                if (is_nl) begin
                  tx_wdata = CHAR_CR;
                  state_d  = ST_NL;
                end
                if (tx_wr_q == TX_AW'(TX_DEPTH - 1)) begin
                  tx_wr_d = '0;
                  tx_wp_d = ~tx_wp_q;
                end else begin
                  tx_wr_d = tx_wr_q + TX_AW'(1);
                end
              end
            end
            FUNC_HOST_GET: begin
              if (!rx_empty) begin
                rx_re                 = 1'b1;
                rsp_d.host_byte_valid = 1'b1;
                if (rx_rd_q == RX_AW'(RX_DEPTH - 1)) begin
                  rx_rd_d = '0;
                  rx_rp_d = ~rx_rp_q;
                end else begin
                  rx_rd_d = rx_rd_q + RX_AW'(1);
                end
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_NL: begin
        tx_we    = 1'b1;
        tx_wdata = CHAR_LF;
        state_d  = ST_RESP;
        if (tx_wr_q == TX_AW'(TX_DEPTH - 1)) begin
          tx_wr_d = '0;
          tx_wp_d = ~tx_wp_q;
        end else begin
          tx_wr_d = tx_wr_q + TX_AW'(1);
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rx_wr_q <= '0;
      rx_wp_q <= 1'b0;
      rx_rd_q <= '0;
      rx_rp_q <= 1'b0;
      tx_wr_q <= '0;
      tx_wp_q <= 1'b0;
      tx_rd_q <= '0;
      tx_rp_q <= 1'b0;
      tx_en_q <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      rx_wr_q <= rx_wr_d;
      rx_wp_q <= rx_wp_d;
      rx_rd_q <= rx_rd_d;
      rx_rp_q <= rx_rp_d;
      tx_wr_q <= tx_wr_d;
      tx_wp_q <= tx_wp_d;
      tx_rd_q <= tx_rd_d;
      tx_rp_q <= tx_rp_d;
      tx_en_q <= tx_en_d;
      rsp_q   <= rsp_d;
    end
  end

  // receive store: line bytes in, host gets out
  urb_ram #(
    .Depth (RX_DEPTH),
    .AddrW (RX_AW),
    .DataW (8)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_q),
    .wdata_i (req_i.data),
    .re_i    (rx_re),
    .raddr_i (rx_rd_q),
    .rdata_o (rx_rdata)
  );

  // transmit store: host puts in, transmitter ticks out
  urb_ram #(
    .Depth (TX_DEPTH),
    .AddrW (TX_AW),
    .DataW (8)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_q),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_rd_q),
    .rdata_o (tx_rdata)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

  // bytes are zero unless their valid flag is set
  always_comb begin
    rsp_o               = rsp_q;
    rsp_o.tx_irq_enable = tx_en_q;
    rsp_o.line_tx_byte  = rsp_q.line_tx_valid ? tx_rdata : 8'h00;
    rsp_o.host_byte     = rsp_q.host_byte_valid ? rx_rdata : 8'h00;
  end

endmodule

`default_nettype wire

### sv/urb_ram.sv
// generic single write port, single read port ram with registered read data
`default_nettype none

module urb_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
